FILE: hdl/rtcu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu_pkg
// Shared types, constants and helper functions for the RTC field to Unix
// seconds converter pipeline.
// ----------------------------------------------------------------------------
package rtcu_pkg;

	localparam int unsigned FieldW    = 8;
	localparam int unsigned InDataW   = 7 * FieldW;
	localparam int unsigned OutDataW  = 32;
	localparam int unsigned DaysW     = 16;
	localparam int unsigned HmsW      = 20;

	localparam logic [14:0] EpochYear = 15'd1970;
	localparam logic [14:0] LastYear  = 15'd2100;
	localparam logic [7:0]  PivotYear = 8'd70;
	localparam logic [14:0] Base20    = 15'd2000;
	localparam logic [14:0] Base19    = 15'd1900;
	localparam logic [7:0]  LastYoff  = 8'd130;

	localparam logic [16:0] DaySeconds  = 17'd86400;
	localparam logic [11:0] HourSeconds = 12'd3600;
	localparam logic [5:0]  MinSeconds  = 6'd60;

	// decoded fields after the first stage
	typedef struct packed {
		logic [7:0] sec;
		logic [7:0] min;
		logic [7:0] hr;
		logic [7:0] day;
		logic [7:0] mon;
		logic [7:0] yr;
		logic [7:0] cen;
	} dec_t;

	// year offset, month index and day offset after the second stage
	typedef struct packed {
		logic       in_range;
		logic [7:0] yoff;
		logic [3:0] mon_idx;
		logic [7:0] day_off;
		logic [7:0] hr;
		logic [7:0] min;
		logic [7:0] sec;
	} date_t;

	// whole days and seconds within the day after the third stage
	typedef struct packed {
		logic             in_range;
		logic [DaysW-1:0] days;
		logic [HmsW-1:0]  hms;
	} count_t;

	// BCD or plain binary decode of one raw byte, no digit check
	function automatic logic [7:0] decode_byte(input logic [7:0] raw, input logic bin);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'd0, raw[7:4]};
		lo = {4'd0, raw[3:0]};
		if (bin)
			return raw;
		return 8'(hi * 8'd10) + lo;
	endfunction

	// days before the first of the month, non-leap year
	function automatic logic [8:0] days_before(input logic [3:0] mon_idx);
		logic [8:0] d;
		case (mon_idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

FILE: hdl/rtcu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu_decode
// Stage 1: unpack the seven raw bytes and decode each as BCD or binary.
// ----------------------------------------------------------------------------
module rtcu_decode import rtcu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               in_valid,
	input  logic [InDataW-1:0] in_data,
	input  logic               bin_mode,
	output logic               valid_s1,
	output dec_t               dec_s1
);

	dec_t dec_d;

	always_comb begin
		dec_d.sec = decode_byte(in_data[7:0],   bin_mode);
		dec_d.min = decode_byte(in_data[15:8],  bin_mode);
		dec_d.hr  = decode_byte(in_data[23:16], bin_mode);
		dec_d.day = decode_byte(in_data[31:24], bin_mode);
		dec_d.mon = decode_byte(in_data[39:32], bin_mode);
		dec_d.yr  = decode_byte(in_data[47:40], bin_mode);
		dec_d.cen = decode_byte(in_data[55:48], bin_mode);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (advance)
			dec_s1 <= dec_d;
	end

endmodule

FILE: hdl/rtcu_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu_date
// Stages 2 and 3: form the four-digit year, clamp month and day, then count
// whole days since the epoch and seconds within the day.
// ----------------------------------------------------------------------------
module rtcu_date import rtcu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   advance,
	input  logic   valid_s1,
	input  dec_t   dec_s1,
	output logic   valid_s3,
	output count_t cnt_s3
);

	logic [14:0] year;
	logic [14:0] yoff_w;
	date_t       date_d;
	logic        valid_s2;
	date_t       date_s2;
	logic        leap;
	logic [DaysW-1:0] days_d;
	logic [HmsW-1:0]  hms_d;
	count_t      cnt_d;

	// stage 2
	always_comb begin
		if (dec_s1.cen != 8'd0)
			year = 15'(dec_s1.cen * 15'd100) + {7'd0, dec_s1.yr};
		else if (dec_s1.yr < PivotYear)
			year = Base20 + {7'd0, dec_s1.yr};
		else
			year = Base19 + {7'd0, dec_s1.yr};
		yoff_w          = year - EpochYear;
		date_d.in_range = (year >= EpochYear) && (year <= LastYear);
		date_d.yoff     = yoff_w[7:0];
		if (dec_s1.mon < 8'd1 || dec_s1.mon > 8'd12)
			date_d.mon_idx = 4'd0;
		else
			date_d.mon_idx = 4'(dec_s1.mon - 8'd1);
		// day zero counts as the first
		date_d.day_off = (dec_s1.day == 8'd0) ? 8'd0 : dec_s1.day - 8'd1;
		date_d.hr      = dec_s1.hr;
		date_d.min     = dec_s1.min;
		date_d.sec     = dec_s1.sec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (advance)
			date_s2 <= date_d;
	end

	// stage 3: within 1970..2100 leap years fall every fourth year from 1972,
	// except 2100
	always_comb begin
		leap = (date_s2.yoff[1:0] == 2'd2) && (date_s2.yoff != LastYoff);
		days_d = DaysW'(date_s2.yoff * 16'd365)
		       + DaysW'((date_s2.yoff + 8'd1) >> 2)
		       + DaysW'(days_before(date_s2.mon_idx))
		       + DaysW'(leap && (date_s2.mon_idx >= 4'd2))
		       + DaysW'(date_s2.day_off);
		hms_d  = HmsW'(date_s2.hr) * HmsW'(HourSeconds)
		       + HmsW'(date_s2.min) * HmsW'(MinSeconds)
		       + HmsW'(date_s2.sec);
		cnt_d.in_range = date_s2.in_range;
		cnt_d.days     = days_d;
		cnt_d.hms      = hms_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (advance)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (advance)
			cnt_s3 <= cnt_d;
	end

endmodule

FILE: hdl/rtcu_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcu_scale
// Stages 4 and 5: scale days to seconds, add the time of day and zero the
// result when the year was out of range.
// ----------------------------------------------------------------------------
module rtcu_scale import rtcu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                valid_s3,
	input  count_t              cnt_s3,
	output logic                valid_s5,
	output logic [OutDataW-1:0] secs_s5
);

	logic                valid_s4;
	logic [OutDataW-1:0] prod_s4;
	logic [HmsW-1:0]     hms_s4;
	logic                in_range_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s4     <= OutDataW'(cnt_s3.days) * OutDataW'(DaySeconds);
			hms_s4      <= cnt_s3.hms;
			in_range_s4 <= cnt_s3.in_range;
			secs_s5     <= in_range_s4 ? prod_s4 + OutDataW'(hms_s4) : '0;
		end
	end

endmodule

FILE: hdl/rtc_fields_to_unix_seconds.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_fields_to_unix_seconds
// Path: an input transfer moves through stages s1 to s5 to reach m_tdata.
// Throughput: one transfer per cycle; the five pipeline stages all advance
// together and hold while m_tvalid is high and m_tready is low.
// Reset: arst_n clears all stage valid bits and sets the byte format to BCD.
// ----------------------------------------------------------------------------
module rtc_fields_to_unix_seconds import rtcu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,   // 1 = plain binary bytes, 0 = BCD
	input  logic                s_tvalid,
	output logic                s_tready,
	// second, minute, hour, day, month, two-digit year, century bytes
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// unix_seconds
	output logic [OutDataW-1:0] m_tdata
);

	logic   fmt_bin_q;
	logic   advance;
	logic   valid_s1;
	dec_t   dec_s1;
	logic   valid_s3;
	count_t cnt_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fmt_bin_q <= 1'b0;
		else if (cfg_we)
			fmt_bin_q <= cfg_wdata;
	end

	// hold the whole pipe only while a result waits at the output
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	rtcu_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.bin_mode (fmt_bin_q),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1)
	);

	rtcu_date u_date (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s3 (valid_s3),
		.cnt_s3   (cnt_s3)
	);

	rtcu_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.valid_s3 (valid_s3),
		.cnt_s3   (cnt_s3),
		.valid_s5 (m_tvalid),
		.secs_s5  (m_tdata)
	);

endmodule

FILE: tb/rtc_fields_to_unix_seconds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_fields_to_unix_seconds_checker
// Watches the input, configuration and output channels of the converter.
// Each input transfer is turned into its expected seconds count at the
// byte format then in force. Each output transfer is compared with the oldest
// expected count. Mismatches and unexpected transfers are counted, and the
// number still owed is reported.
// ----------------------------------------------------------------------------
module rtc_fields_to_unix_seconds_checker import rtcu_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [OutDataW-1:0] m_tdata,
	output int                  errors,
	output int                  pending
);

	localparam int unsigned FirstYear  = 1970;
	localparam int unsigned FinalYear  = 2100;
	localparam int unsigned PivotYy    = 70;
	localparam int unsigned SecsPerDay = 86400;
	localparam int unsigned SecsPerHr  = 3600;
	localparam int unsigned SecsPerMin = 60;

	logic                bin_mode;
	logic [OutDataW-1:0] expected_seconds [$];
	logic [OutDataW-1:0] want;

	initial begin
		errors  = 0;
		pending = 0;
	end

	function automatic int unsigned field_value(input logic [7:0] raw, input logic bin);
		if (bin)
			return int'(raw);
		// no digit check: nibbles above nine pass straight through
		return int'(raw[7:4]) * 10 + int'(raw[3:0]);
	endfunction

	function automatic bit leap_year(input int unsigned y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int unsigned leap_days_through(input int unsigned y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic int unsigned month_length(input int unsigned m);
		case (m)
			2:       return 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic logic [OutDataW-1:0] unix_seconds_of(input logic [InDataW-1:0] item,
			input logic bin);
		int unsigned secs, mins, hours, mday, month, yy, cc, year, days;
		longint unsigned total;
		secs  = field_value(item[7:0], bin);
		mins  = field_value(item[15:8], bin);
		hours = field_value(item[23:16], bin);
		mday  = field_value(item[31:24], bin);
		month = field_value(item[39:32], bin);
		yy    = field_value(item[47:40], bin);
		cc    = field_value(item[55:48], bin);

		// no century byte: fall back to the two-digit pivot
		if (cc != 0)
			year = cc * 100 + yy;
		else if (yy < PivotYy)
			year = 2000 + yy;
		else
			year = 1900 + yy;

		if (year < FirstYear || year > FinalYear)
			return '0;

		days = (year - FirstYear) * 365
			+ leap_days_through(year - 1) - leap_days_through(FirstYear - 1);
		if (month < 1 || month > 12)
			month = 1;
		for (int unsigned m = 1; m < month; m++)
			days += month_length(m);
		if (leap_year(year) && month > 2)
			days += 1;
		if (mday < 1)
			mday = 1;
		days += mday - 1;

		total = longint'(days) * SecsPerDay + longint'(hours) * SecsPerHr
			+ longint'(mins) * SecsPerMin + longint'(secs);
		return total[OutDataW-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_mode = 1'b0;
			expected_seconds.delete();
			pending = 0;
		end else begin
			// predict with the mode in force before any write at this edge
			if (s_tvalid && s_tready)
				expected_seconds.push_back(unix_seconds_of(s_tdata, bin_mode));
			if (cfg_we)
				bin_mode = cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (expected_seconds.size() == 0) begin
					if (errors < 10)
						$display("unexpected transfer: unix_seconds %0d with nothing owed",
							m_tdata);
					errors++;
				end else begin
					want = expected_seconds.pop_front();
					if (m_tdata !== want) begin
						if (errors < 10)
							$display("unix_seconds mismatch: expected %0d, got %0d",
								want, m_tdata);
						errors++;
					end
				end
			end
			pending = expected_seconds.size();
		end
	end

endmodule

FILE: tb/rtc_fields_to_unix_seconds_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_fields_to_unix_seconds_tb
// Drives clock-chip byte sets into the converter in BCD and binary mode:
// a directed set of calendar corners, then random phases of mostly valid
// dates with noise, under random idling on both sides, a long output stall
// and drains before each mode change. The checker does all comparison.
// ----------------------------------------------------------------------------
module rtc_fields_to_unix_seconds_tb;
	import rtcu_pkg::*;

	localparam int CycleLimit = 200000;
	localparam int Phases     = 6;
	localparam int PhaseItems = 315;
	localparam int HoldCycles = 200;
	localparam int IdlePct    = 28;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_wdata = 1'b0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata   = '0;
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [OutDataW-1:0] m_tdata;

	int   errors;
	int   pending;
	int   cycles    = 0;
	int   hold_left = 0;
	logic hold_req  = 1'b0;
	logic hold_done = 1'b0;
	logic steady    = 1'b0;
	logic tx_mode   = 1'b0;

	rtc_fields_to_unix_seconds dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	rtc_fields_to_unix_seconds_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready  <= 1'b0;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else if (steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= IdlePct);
		end
	end

	function automatic logic [InDataW-1:0] clock_bytes(input logic [7:0] secs,
			input logic [7:0] mins, input logic [7:0] hours, input logic [7:0] mday,
			input logic [7:0] month, input logic [7:0] yy, input logic [7:0] cc);
		return {cc, yy, month, mday, hours, mins, secs};
	endfunction

	function automatic logic [7:0] to_field(input int unsigned v, input logic bin);
		if (bin)
			return 8'(v);
		return {4'(v / 10), 4'(v % 10)};
	endfunction

	// mostly plausible dates in the current encoding, some noise
	function automatic logic [InDataW-1:0] random_item(input logic bin);
		int unsigned cc, yy, roll;
		logic [7:0] f [7];
		roll = $urandom_range(99);
		if (roll < 15)
			return InDataW'({$urandom(), $urandom()});
		case ($urandom_range(3))
			0:       cc = 0;
			1:       cc = 19;
			2:       cc = 20;
			default: cc = 21;
		endcase
		yy   = (cc == 21 && $urandom_range(3) != 0) ? 0 : $urandom_range(99);
		f[6] = to_field(cc, bin);
		f[5] = to_field(yy, bin);
		f[4] = to_field(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1),
			bin);
		f[3] = to_field(($urandom_range(19) == 0) ? 0 : $urandom_range(31, 1), bin);
		f[2] = to_field($urandom_range(23), bin);
		f[1] = to_field($urandom_range(59), bin);
		f[0] = to_field($urandom_range(59), bin);
		if (roll < 30)
			f[$urandom_range(6)] = 8'($urandom());
		return {f[6], f[5], f[4], f[3], f[2], f[1], f[0]};
	endfunction

	task automatic send_item(input logic [InDataW-1:0] item);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= item;
		do @(posedge clk); while (!s_tready);
	endtask

	// drain the pipeline, then change the number format
	task automatic set_mode(input logic bin);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= bin;
		@(posedge clk);
		cfg_we  <= 1'b0;
		tx_mode = bin;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// BCD corners, mode as left by reset
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h19));
		send_item(clock_bytes(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h00, 8'h21));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h69, 8'h19));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h21));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(clock_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h69, 8'h00));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h70, 8'h00));
		send_item(clock_bytes(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h00));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24, 8'h20));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h20));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00, 8'h21));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h38, 8'h20));
		send_item(clock_bytes(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h21));
		send_item(clock_bytes(8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'h0E, 8'h0F, 8'h20));
		send_item(clock_bytes(8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h50, 8'h20));

		// binary corners
		set_mode(1'b1);
		send_item(clock_bytes(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd70, 8'd19));
		send_item(clock_bytes(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd21));
		send_item(clock_bytes(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd255, 8'd0));
		send_item(clock_bytes(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd69, 8'd0));
		send_item(clock_bytes(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd70, 8'd0));
		send_item(clock_bytes(8'd1, 8'd2, 8'd3, 8'd29, 8'd2, 8'd100, 8'd20));
		send_item(clock_bytes(8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd201, 8'd19));

		for (int p = 0; p < Phases; p++) begin
			set_mode(p[0]);
			// one phase runs with no idling on either side
			steady = (p == 2);
			for (int n = 0; n < PhaseItems; n++) begin
				if (p == 3 && n == 40)
					hold_req = 1'b1;
				send_item(random_item(tx_mode));
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: rtc_fields_to_unix_seconds.f
hdl/rtcu_pkg.sv
hdl/rtcu_decode.sv
hdl/rtcu_date.sv
hdl/rtcu_scale.sv
hdl/rtc_fields_to_unix_seconds.sv
tb/rtc_fields_to_unix_seconds_checker.sv
tb/rtc_fields_to_unix_seconds_tb.sv
